// ===== sv/cpnd_pkg.sv =====
package cpnd_pkg;

    // Field widths of the two channels
    localparam int LETTER_W = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;

    // Default width of the number being built
    localparam int NUM_WIDTH_DEF = 32;

    // Final proof status codes (also used as decode error codes)
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_CHAR   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_STRAY_Z    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_UNFINISHED = 3'd6;

    // Input item kinds
    localparam logic FUNC_LETTER = 1'b0;
    localparam logic FUNC_END    = 1'b1;

    // Result item kinds
    localparam logic KIND_NUMBER = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Character codes
    localparam logic [LETTER_W-1:0] CH_A_M1  = 8'h40;  // one below 'A'
    localparam logic [LETTER_W-1:0] CH_T     = 8'h54;
    localparam logic [LETTER_W-1:0] CH_Y     = 8'h59;
    localparam logic [LETTER_W-1:0] CH_Z     = 8'h5A;
    localparam logic [LETTER_W-1:0] CH_QMARK = 8'h3F;

endpackage

// ===== sv/cpnd_if.sv =====
// Proof letter channel
interface cpnd_in_if;
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic [cpnd_pkg::LETTER_W-1:0]  letter;

    modport source (output valid, output func, output letter, input ready);
    modport sink   (input valid, input func, input letter, output ready);
endinterface

// Decoded number / status channel
interface cpnd_out_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [cpnd_pkg::VALUE_W-1:0]   value;
    logic [cpnd_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output kind, output value, output status, input ready);
    modport sink   (input valid, input kind, input value, input status, output ready);
endinterface

// ===== sv/compressed_proof_number_decoder.sv =====
// Compressed proof number decoder: takes one proof letter (or an end-of-proof item)
// per cycle on proof and gives at most one result on step, in the cycle after the
// transfer. U..Y append a base-5 digit, A..T finish a number and emit it, Z repeats
// a step (value 0) right after a finished number, '?' emits the all-ones unknown
// marker. After a bad character or a decode error, letters emit nothing until the
// end item, which always returns the final status and clears all state. Throughput
// is one item per cycle: the decode is a single shift-and-add step with an overflow
// check feeding one output register, and proof stays ready whenever that register
// is empty or being taken in the same cycle.
module compressed_proof_number_decoder #(
    parameter int NUM_WIDTH = cpnd_pkg::NUM_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    cpnd_in_if.sink           proof,
    cpnd_out_if.source        step
);
    import cpnd_pkg::*;

    localparam int WIDE_W = NUM_WIDTH + 5;

    // Decoder state
    logic [NUM_WIDTH-1:0] partial_reg, partial_next;
    logic                 just_finished_reg, just_finished_next;
    logic [STATUS_W-1:0]  decode_error_reg, decode_error_next;
    logic                 bad_char_reg, bad_char_next;
    logic                 unknown_reg, unknown_next;
    logic                 any_letter_reg, any_letter_next;

    // Output register
    logic                 out_valid_reg;
    logic                 kind_reg, kind_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 emit;

    logic                 in_xfer;
    logic [LETTER_W-1:0]  ft_off, dig_off;
    logic                 is_q, is_ft, is_dig, is_z, is_legal;
    logic [WIDE_W-1:0]    p_ext, grow20, grow5;
    logic                 ovf20, ovf5;
    logic [NUM_WIDTH+VALUE_W-1:0] num_ext;
    logic [STATUS_W-1:0]  end_status;

    assign proof.ready = !out_valid_reg || step.ready;
    assign in_xfer     = proof.valid && proof.ready;

    // Letter classes
    assign is_q     = (proof.letter == CH_QMARK);
    assign is_ft    = (proof.letter > CH_A_M1) && (proof.letter <= CH_T);
    assign is_dig   = (proof.letter > CH_T) && (proof.letter <= CH_Y);
    assign is_z     = (proof.letter == CH_Z);
    assign is_legal = is_q || is_ft || is_dig || is_z;

    // Digit values: 1..20 for A..T, 1..5 for U..Y
    assign ft_off  = proof.letter - CH_A_M1;
    assign dig_off = proof.letter - CH_T;

    // partial*20 + d and partial*5 + d as shift-and-add, with headroom for overflow
    assign p_ext  = WIDE_W'(partial_reg);
    assign grow20 = (p_ext << 4) + (p_ext << 2) + WIDE_W'(ft_off[4:0]);
    assign grow5  = (p_ext << 2) + p_ext + WIDE_W'(dig_off[2:0]);
    assign ovf20  = |grow20[WIDE_W-1:NUM_WIDTH];
    assign ovf5   = |grow5[WIDE_W-1:NUM_WIDTH];
    assign num_ext = {{VALUE_W{1'b0}}, grow20[NUM_WIDTH-1:0]};

    // Final status by priority
    always_comb
    begin
        if (bad_char_reg)
            end_status = ST_BAD_CHAR;
        else if (decode_error_reg != ST_OK)
            end_status = decode_error_reg;
        else if (!any_letter_reg)
            end_status = ST_EMPTY;
        else if (partial_reg != '0)
            end_status = ST_UNFINISHED;
        else if (unknown_reg)
            end_status = ST_INCOMPLETE;
        else
            end_status = ST_OK;
    end

    // Next state and result
    always_comb
    begin
        partial_next       = partial_reg;
        just_finished_next = just_finished_reg;
        decode_error_next  = decode_error_reg;
        bad_char_next      = bad_char_reg;
        unknown_next       = unknown_reg;
        any_letter_next    = any_letter_reg;
        emit               = 1'b0;
        kind_next          = KIND_NUMBER;
        value_next         = '0;
        status_next        = ST_OK;

        if (in_xfer)
        begin
            if (proof.func == FUNC_END)
            begin
                emit               = 1'b1;
                kind_next          = KIND_STATUS;
                status_next        = end_status;
                partial_next       = '0;
                just_finished_next = 1'b0;
                decode_error_next  = ST_OK;
                bad_char_next      = 1'b0;
                unknown_next       = 1'b0;
                any_letter_next    = 1'b0;
            end
            else
            begin
                any_letter_next = 1'b1;
                if (!is_legal)
                    bad_char_next = 1'b1;
                else if (!bad_char_reg && decode_error_reg == ST_OK)
                begin
                    if (is_q)
                    begin
                        unknown_next       = 1'b1;
                        partial_next       = '0;
                        just_finished_next = 1'b1;
                        emit               = 1'b1;
                        value_next         = '1;
                    end
                    else if (is_ft)
                    begin
                        if (ovf20)
                            decode_error_next = ST_OVERFLOW;
                        else
                        begin
                            partial_next       = '0;
                            just_finished_next = 1'b1;
                            emit               = 1'b1;
                            value_next         = num_ext[VALUE_W-1:0];
                        end
                    end
                    else if (is_dig)
                    begin
                        if (ovf5)
                            decode_error_next = ST_OVERFLOW;
                        else
                        begin
                            partial_next       = grow5[NUM_WIDTH-1:0];
                            just_finished_next = 1'b0;
                        end
                    end
                    else
                    begin
                        // Z repeats the previous step only right after a finished number
                        if (!just_finished_reg)
                            decode_error_next = ST_STRAY_Z;
                        else
                        begin
                            just_finished_next = 1'b0;
                            emit               = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg       <= '0;
            just_finished_reg <= 1'b0;
            decode_error_reg  <= ST_OK;
            bad_char_reg      <= 1'b0;
            unknown_reg       <= 1'b0;
            any_letter_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            partial_reg       <= partial_next;
            just_finished_reg <= just_finished_next;
            decode_error_reg  <= decode_error_next;
            bad_char_reg      <= bad_char_next;
            unknown_reg       <= unknown_next;
            any_letter_reg    <= any_letter_next;
            if (in_xfer)
                out_valid_reg <= emit;
            else if (step.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded only when a result is produced
    always_ff @(posedge clk)
    begin
        if (in_xfer && emit)
        begin
            kind_reg   <= kind_next;
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign step.valid  = out_valid_reg;
    assign step.kind   = kind_reg;
    assign step.value  = value_reg;
    assign step.status = status_reg;

endmodule

// ===== sv/cpnd_checker.sv =====
module cpnd_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           in_func,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           out_kind,
    input  logic [cpnd_pkg::VALUE_W-1:0]   out_value,
    input  logic [cpnd_pkg::STATUS_W-1:0]  out_status
);
    import cpnd_pkg::*;

    // A stalled result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value)
            && $stable(out_status))
        else $error("result changed while stalled");

    // An end item always yields a status result in the next cycle
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_func == FUNC_END |=> out_valid && out_kind == KIND_STATUS)
        else $error("end item gave no status result");

    // Status results carry a zero value and a defined code
    a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_STATUS |-> out_value == '0 && out_status <= ST_UNFINISHED)
        else $error("malformed status result");

    // Step numbers carry a zero status
    a_number_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_NUMBER |-> out_status == ST_OK)
        else $error("step number with nonzero status");

    // A letter never yields a status result
    a_letter_kind: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_func == FUNC_LETTER |=> !out_valid || out_kind == KIND_NUMBER)
        else $error("letter gave a status result");

endmodule

bind compressed_proof_number_decoder cpnd_checker u_cpnd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (proof.valid),
    .in_ready   (proof.ready),
    .in_func    (proof.func),
    .out_valid  (step.valid),
    .out_ready  (step.ready),
    .out_kind   (step.kind),
    .out_value  (step.value),
    .out_status (step.status)
);

// ===== tb/compressed_proof_number_decoder_tb.sv =====
`timescale 1ns / 100ps

module compressed_proof_number_decoder_tb;
    import cpnd_pkg::*;

    localparam int NUM_W       = NUM_WIDTH_DEF;
    localparam int ITEMS_PHASE = 370;
    localparam int HOLD_CYCLES = 60;

    // Largest number that still fits the partial register
    localparam logic [63:0] NUM_MAX = (64'd1 << NUM_W) - 64'd1;

    // Letters not in the package
    localparam logic [LETTER_W-1:0] CH_A     = CH_A_M1 + 8'd1;
    localparam logic [LETTER_W-1:0] CH_B     = CH_A_M1 + 8'd2;
    localparam logic [LETTER_W-1:0] CH_U     = CH_T + 8'd1;
    localparam logic [LETTER_W-1:0] CH_W     = CH_T + 8'd3;
    localparam logic [LETTER_W-1:0] CH_LOW_A = 8'h61;  // lowercase a

    typedef struct packed {
        logic                kind;
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } step_t;

    typedef struct packed {
        logic                func;
        logic [LETTER_W-1:0] letter;
        logic                fixed;   // typed-in expectation below
        step_t               res;
    } stim_row_t;

    localparam step_t NO_STEP = '{KIND_NUMBER, 32'd0, ST_OK};

    // Directed stimulus; rows with fixed set carry the expected result
    localparam stim_row_t DIRECTED [25] = '{
        '{FUNC_END,    8'h00,    1'b1, '{KIND_STATUS, 32'd0,          ST_EMPTY}},
        '{FUNC_LETTER, CH_A,     1'b1, '{KIND_NUMBER, 32'd1,          ST_OK}},
        '{FUNC_LETTER, CH_T,     1'b1, '{KIND_NUMBER, 32'd20,         ST_OK}},
        '{FUNC_LETTER, CH_Z,     1'b1, '{KIND_NUMBER, 32'd0,          ST_OK}},
        '{FUNC_LETTER, CH_QMARK, 1'b1, '{KIND_NUMBER, 32'hFFFF_FFFF,  ST_OK}},
        '{FUNC_LETTER, CH_Z,     1'b1, '{KIND_NUMBER, 32'd0,          ST_OK}},
        '{FUNC_END,    8'hFF,    1'b1, '{KIND_STATUS, 32'd0,          ST_INCOMPLETE}},
        '{FUNC_LETTER, CH_U,     1'b0, NO_STEP},
        '{FUNC_LETTER, CH_Y,     1'b0, NO_STEP},
        '{FUNC_LETTER, CH_B,     1'b0, NO_STEP},
        '{FUNC_LETTER, CH_Z,     1'b0, NO_STEP},
        '{FUNC_END,    8'h00,    1'b1, '{KIND_STATUS, 32'd0,          ST_OK}},
        '{FUNC_LETTER, CH_Z,     1'b0, NO_STEP},
        '{FUNC_LETTER, CH_A,     1'b0, NO_STEP},
        '{FUNC_END,    8'h00,    1'b1, '{KIND_STATUS, 32'd0,          ST_STRAY_Z}},
        '{FUNC_LETTER, CH_Y,     1'b0, NO_STEP},
        '{FUNC_LETTER, CH_QMARK, 1'b1, '{KIND_NUMBER, 32'hFFFF_FFFF,  ST_OK}},
        '{FUNC_LETTER, CH_W,     1'b0, NO_STEP},
        '{FUNC_END,    8'h00,    1'b1, '{KIND_STATUS, 32'd0,          ST_UNFINISHED}},
        '{FUNC_LETTER, CH_LOW_A, 1'b0, NO_STEP},
        '{FUNC_LETTER, CH_A,     1'b0, NO_STEP},
        '{FUNC_END,    8'h00,    1'b1, '{KIND_STATUS, 32'd0,          ST_BAD_CHAR}},
        '{FUNC_LETTER, CH_Z,     1'b0, NO_STEP},
        '{FUNC_LETTER, 8'hFF,    1'b0, NO_STEP},
        '{FUNC_END,    8'h00,    1'b1, '{KIND_STATUS, 32'd0,          ST_BAD_CHAR}}
    };

    logic clk;
    logic rst_n;

    cpnd_in_if  proof_if ();
    cpnd_out_if step_if ();

    compressed_proof_number_decoder #(
        .NUM_WIDTH (NUM_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .proof (proof_if),
        .step  (step_if)
    );

    // Decoder state as the testbench tracks it
    logic [63:0]         partial;
    logic                just_done;
    logic [STATUS_W-1:0] first_err;
    logic                bad_seen;
    logic                unknown_seen;
    logic                letter_seen;

    step_t expected_steps [$];
    int    mismatches;
    int    sent_items;
    int    send_idle_pct;
    int    recv_stall_pct;
    int    hold_left;

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Run limit
    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void clear_decoder();
        partial      = '0;
        just_done    = 1'b0;
        first_err    = ST_OK;
        bad_seen     = 1'b0;
        unknown_seen = 1'b0;
        letter_seen  = 1'b0;
    endfunction

    // Advance the tracked state by one item; returns 1 when a result is due
    function automatic bit decode_item(input logic f, input logic [LETTER_W-1:0] ch,
                                       output step_t res);
        logic [63:0] grown;
        res = NO_STEP;
        if (f == FUNC_END)
        begin
            res.kind = KIND_STATUS;
            if (bad_seen)
                res.status = ST_BAD_CHAR;
            else if (first_err != ST_OK)
                res.status = first_err;
            else if (!letter_seen)
                res.status = ST_EMPTY;
            else if (partial != 0)
                res.status = ST_UNFINISHED;
            else if (unknown_seen)
                res.status = ST_INCOMPLETE;
            else
                res.status = ST_OK;
            clear_decoder();
            return 1'b1;
        end
        letter_seen = 1'b1;
        if (!((ch > CH_A_M1 && ch <= CH_Z) || ch == CH_QMARK))
        begin
            bad_seen = 1'b1;
            return 1'b0;
        end
        if (bad_seen || first_err != ST_OK)
            return 1'b0;
        if (ch == CH_QMARK)
        begin
            unknown_seen = 1'b1;
            partial      = '0;
            just_done    = 1'b1;
            res.value    = '1;
            return 1'b1;
        end
        if (ch <= CH_T)
        begin
            grown = partial * 64'd20 + 64'(ch - CH_A_M1);
            if (grown > NUM_MAX)
            begin
                first_err = ST_OVERFLOW;
                return 1'b0;
            end
            res.value = grown[VALUE_W-1:0];
            partial   = '0;
            just_done = 1'b1;
            return 1'b1;
        end
        if (ch <= CH_Y)
        begin
            grown = partial * 64'd5 + 64'(ch - CH_T);
            if (grown > NUM_MAX)
            begin
                first_err = ST_OVERFLOW;
                return 1'b0;
            end
            partial   = grown;
            just_done = 1'b0;
            return 1'b0;
        end
        // Z repeats a step only right after a finished number
        if (!just_done)
        begin
            first_err = ST_STRAY_Z;
            return 1'b0;
        end
        just_done = 1'b0;
        return 1'b1;
    endfunction

    // One transfer on the proof channel, then queue what it should produce
    task automatic send_item(input logic f, input logic [LETTER_W-1:0] ch,
                             input bit use_typed, input step_t typed);
        step_t res;
        bit    due;
        while ($urandom_range(99) < send_idle_pct)
        begin
            proof_if.valid <= 1'b0;
            @(posedge clk);
        end
        proof_if.valid  <= 1'b1;
        proof_if.func   <= f;
        proof_if.letter <= ch;
        do @(posedge clk); while (!proof_if.ready);
        sent_items++;
        due = decode_item(f, ch, res);
        if (use_typed)
            expected_steps = {expected_steps, typed};
        else if (due)
            expected_steps = {expected_steps, res};
    endtask

    task automatic send_letter(input logic [LETTER_W-1:0] ch);
        send_item(FUNC_LETTER, ch, 1'b0, NO_STEP);
    endtask

    // Sender goes quiet until every queued result has come back
    task automatic drain_steps();
        proof_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_steps.size() != 0)
            @(posedge clk);
    endtask

    // Base-5 digits, then, unless unfinished, a finishing letter or '?', sometimes a repeat Z
    task automatic send_number(input bit unfinished);
        int n_digits;
        n_digits = ($urandom_range(99) < 6) ? $urandom_range(10, 15) : $urandom_range(0, 3);
        repeat (n_digits)
            send_letter(CH_T + 8'($urandom_range(1, 5)));
        if (unfinished)
            return;
        if ($urandom_range(99) < 10)
            send_letter(CH_QMARK);
        else
            send_letter(CH_A_M1 + 8'($urandom_range(1, 20)));
        if ($urandom_range(99) < 30)
            send_letter(CH_Z);
    endtask

    // One proof: mostly well formed, some broken, some noise
    task automatic send_proof();
        int pick;
        int n_numbers;
        int fault_at;
        int fault_kind;
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            n_numbers  = $urandom_range(1, 8);
            fault_at   = (pick < 65) ? -1 : $urandom_range(0, n_numbers - 1);
            fault_kind = $urandom_range(2);
            for (int i = 0; i < n_numbers; i++)
            begin
                if (i == fault_at && fault_kind == 0)
                    send_letter(CH_Z);
                else if (i == fault_at && fault_kind == 1)
                    send_letter(8'($urandom_range(255)));
                send_number(i == fault_at && fault_kind == 2);
            end
        end
        else if (pick < 90)
        begin
            repeat ($urandom_range(0, 8))
                send_letter(8'($urandom_range(255)));
        end
        else
        begin
            repeat ($urandom_range(1, 10))
                send_letter(($urandom_range(26) == 26) ? CH_QMARK
                                                        : CH_A_M1 + 8'($urandom_range(1, 26)));
        end
        send_item(FUNC_END, 8'($urandom_range(255)), 1'b0, NO_STEP);
    endtask

    // Result side: check each transfer and pick the next ready
    always @(posedge clk)
    begin
        step_t want;
        if (rst_n && step_if.valid && step_if.ready)
        begin
            if (expected_steps.size() == 0)
            begin
                $display("%0t: result with none expected: kind %0d value %h status %0d",
                         $time, step_if.kind, step_if.value, step_if.status);
                mismatches++;
            end
            else
            begin
                want = expected_steps.pop_front();
                if (step_if.kind !== want.kind)
                begin
                    $display("%0t: kind expected %0d actual %0d",
                             $time, want.kind, step_if.kind);
                    mismatches++;
                end
                if (step_if.value !== want.value)
                begin
                    $display("%0t: value expected %h actual %h",
                             $time, want.value, step_if.value);
                    mismatches++;
                end
                if (step_if.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, step_if.status);
                    mismatches++;
                end
            end
        end
        if (hold_left != 0)
        begin
            step_if.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else
        begin
            step_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stimulus
    initial
    begin
        int send_pct [4];
        int recv_pct [4];
        send_pct = '{0, 55, 0, 13};
        recv_pct = '{0, 0, 55, 13};

        mismatches      = 0;
        sent_items      = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_left       = 0;
        clear_decoder();
        rst_n           = 1'b0;
        proof_if.valid  = 1'b0;
        proof_if.func   = FUNC_LETTER;
        proof_if.letter = '0;
        step_if.ready   = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows
        foreach (DIRECTED[i])
            send_item(DIRECTED[i].func, DIRECTED[i].letter, DIRECTED[i].fixed, DIRECTED[i].res);
        drain_steps();

        // Long receiver hold-off while finishing letters keep coming
        hold_left <= HOLD_CYCLES;
        repeat (30)
            send_letter(CH_A_M1 + 8'($urandom_range(1, 20)));
        send_item(FUNC_END, 8'h00, 1'b0, NO_STEP);
        drain_steps();

        // Random proofs under each idling mix
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  <= send_pct[p];
            recv_stall_pct <= recv_pct[p];
            sent_items = 0;
            while (sent_items < ITEMS_PHASE)
                send_proof();
            drain_steps();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_steps.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
